// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the serial frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // APB map: one 32-bit register
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_HEAD_BYTE_ADDR = 2'd0;

  // frame types carrying a 16-bit sum
  localparam logic [BYTE_W-1:0] TYPE_SUM_A = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_SUM_B = 8'h02;

  localparam logic [BYTE_W-1:0] MIN_SUM_LEN = 8'd2;

  typedef struct packed {
    logic              receiving;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              frame_done;
    logic [BYTE_W-1:0] frame_seq;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] frame_len;
    logic              sum_checked;
    logic              sum_ok;
  } sfr_result_t;

  function automatic logic is_sum_type(input logic [BYTE_W-1:0] frame_type);
    return (frame_type == TYPE_SUM_A) || (frame_type == TYPE_SUM_B);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sfr_queue.sv =====
// Front of the receiver: short byte queue between the input channel and the deframer.
// Depends on sfr_pkg.
`default_nettype none

module sfr_queue
  import sfr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_stall_o,
  input  wire logic [BYTE_W-1:0] push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic [BYTE_W-1:0]      pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_stall_o = (cnt_q == FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfr_deframe.sv =====
// Back of the receiver: header hunt, payload streaming, sum16 check, output register.
// Depends on sfr_pkg.
`default_nettype none

module sfr_deframe
  import sfr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [BYTE_W-1:0] head_byte_i,
  input  wire logic              item_valid_i,
  input  wire logic [BYTE_W-1:0] item_byte_i,
  output logic                   item_pop_o,
  output logic                   res_valid_o,
  input  wire logic              res_stall_i,
  output sfr_result_t            res_o
);

  // hunt window, [0] oldest
  logic [BYTE_W-1:0] win0_q, win0_d, win1_q, win1_d, win2_q, win2_d;
  logic              in_frame_q, in_frame_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] seq_q, seq_d;
  logic [BYTE_W-1:0] type_q, type_d;
  // sum of payload bytes except the two most recent
  logic [SUM_W-1:0]  body_q, body_d;
  logic [BYTE_W-1:0] rec0_q, rec0_d, rec1_q, rec1_d;
  logic              res_valid_q, res_valid_d;
  sfr_result_t       res_q, res_d;
  logic              take;
  logic [BYTE_W-1:0] cnt_inc;
  logic              checked;

  assign take        = item_valid_i && (!res_valid_q || !res_stall_i);
  assign item_pop_o  = take;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cnt_inc     = cnt_q + BYTE_W'(1);

  always_comb begin
    win0_d     = win0_q;
    win1_d     = win1_q;
    win2_d     = win2_q;
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    seq_d      = seq_q;
    type_d     = type_q;
    body_d     = body_q;
    rec0_d     = rec0_q;
    rec1_d     = rec1_q;
    res_d      = '0;
    checked    = 1'b0;

    if (!in_frame_q) begin
      win0_d = win1_q;
      win1_d = win2_q;
      win2_d = item_byte_i;
      if (win0_q == head_byte_i) begin
        seq_d      = win1_q;
        type_d     = win2_q;
        len_d      = item_byte_i;
        cnt_d      = '0;
        body_d     = '0;
        rec0_d     = '0;
        rec1_d     = '0;
        in_frame_d = 1'b1;
        if (item_byte_i == '0) begin
          // empty frame: done at once, a checked type always fails
          checked           = is_sum_type(win2_q);
          res_d.frame_done  = 1'b1;
          res_d.frame_seq   = win1_q;
          res_d.frame_type  = win2_q;
          res_d.frame_len   = '0;
          res_d.sum_checked = checked;
          res_d.sum_ok      = 1'b0;
          in_frame_d        = 1'b0;
          win0_d            = '0;
          win1_d            = '0;
          win2_d            = '0;
        end
      end
    end else begin
      res_d.payload_valid = 1'b1;
      res_d.payload_byte  = item_byte_i;
      res_d.payload_index = cnt_q;
      body_d = body_q + SUM_W'(rec0_q);
      rec0_d = rec1_q;
      rec1_d = item_byte_i;
      cnt_d  = cnt_inc;
      if (cnt_inc >= len_q) begin
        checked           = is_sum_type(type_q);
        res_d.frame_done  = 1'b1;
        res_d.frame_seq   = seq_q;
        res_d.frame_type  = type_q;
        res_d.frame_len   = len_q;
        res_d.sum_checked = checked;
        // trailer is low byte then high byte
        res_d.sum_ok      = checked && (len_q >= MIN_SUM_LEN) &&
                            (body_d == {item_byte_i, rec1_q});
        in_frame_d        = 1'b0;
        cnt_d             = '0;
        win0_d            = '0;
        win1_d            = '0;
        win2_d            = '0;
      end
    end
    res_d.receiving = in_frame_d;
  end

  assign res_valid_d = take ? 1'b1 : (res_valid_q && res_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q      <= '0;
      win1_q      <= '0;
      win2_q      <= '0;
      in_frame_q  <= 1'b0;
      cnt_q       <= '0;
      len_q       <= '0;
      seq_q       <= '0;
      type_q      <= '0;
      body_q      <= '0;
      rec0_q      <= '0;
      rec1_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        win0_q     <= win0_d;
        win1_q     <= win1_d;
        win2_q     <= win2_d;
        in_frame_q <= in_frame_d;
        cnt_q      <= cnt_d;
        len_q      <= len_d;
        seq_q      <= seq_d;
        type_q     <= type_d;
        body_q     <= body_d;
        rec0_q     <= rec0_d;
        rec1_q     <= rec1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/serial_frame_receiver_sum16.sv =====
// Serial frame receiver with sum16 check: byte queue, deframer, APB head_byte register.
// After a byte is accepted, its result is registered in a queue slot, then in the
// deframer's output register. Throughput: one byte per cycle while the output is not
// stalled, set by the deframer's state update; the queue (QDEPTH entries) absorbs output stalls.
// Reset: asynchronous active low; clears head_byte, hunt window, frame state and queue.
// Depends on sfr_pkg, sfr_queue, sfr_deframe.
`default_nettype none

module serial_frame_receiver_sum16
  import sfr_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // APB
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  // byte input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     rx_byte_i,
  // results
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       receiving_o,
  output logic                       payload_valid_o,
  output logic [BYTE_W-1:0]          payload_byte_o,
  output logic [BYTE_W-1:0]          payload_index_o,
  output logic                       frame_done_o,
  output logic [BYTE_W-1:0]          frame_seq_o,
  output logic [BYTE_W-1:0]          frame_type_o,
  output logic [BYTE_W-1:0]          frame_len_o,
  output logic                       sum_checked_o,
  output logic                       sum_ok_o
);

  logic [BYTE_W-1:0] head_byte_q;
  logic              q_valid, q_pop;
  logic [BYTE_W-1:0] q_byte;
  sfr_result_t       res;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_byte_q <= '0;
    end else if (psel && penable && pwrite && (paddr == REG_HEAD_BYTE_ADDR)) begin
      head_byte_q <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = (paddr == REG_HEAD_BYTE_ADDR) ?
                  {{(APB_DATA_W-BYTE_W){1'b0}}, head_byte_q} : '0;

  sfr_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (rx_byte_i),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   (q_byte)
  );

  sfr_deframe u_deframe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_byte_i  (head_byte_q),
    .item_valid_i (q_valid),
    .item_byte_i  (q_byte),
    .item_pop_o   (q_pop),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign receiving_o     = res.receiving;
  assign payload_valid_o = res.payload_valid;
  assign payload_byte_o  = res.payload_byte;
  assign payload_index_o = res.payload_index;
  assign frame_done_o    = res.frame_done;
  assign frame_seq_o     = res.frame_seq;
  assign frame_type_o    = res.frame_type;
  assign frame_len_o     = res.frame_len;
  assign sum_checked_o   = res.sum_checked;
  assign sum_ok_o        = res.sum_ok;

  // a completed frame always drops back to hunting
  a_done_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !receiving_o)
    else $error("frame_done reported while still receiving");

  // checksum flags only on frame end, and ok implies checked
  a_sum_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sum_ok_o || sum_checked_o) |-> frame_done_o && sum_checked_o)
    else $error("checksum flags outside a checked frame end");

  // a payload byte that does not end the frame leaves the block inside it
  a_payload_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o && !frame_done_o |-> receiving_o)
    else $error("mid-frame payload byte without receiving");

endmodule

`default_nettype wire
